FILE: src/sbpd_pkg.sv
// Shared types, constants and register codes of the single-button PWM dimmer.
package sbpd_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CfgRampTop     = 3'd0;
  localparam logic [2:0] CfgRampBottom  = 3'd1;
  localparam logic [2:0] CfgStepDivider = 3'd2;
  localparam logic [2:0] CfgShortLimit  = 3'd3;
  localparam logic [2:0] CfgLongLimit   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [7:0] RampTopRst     = 8'd250;
  localparam logic [7:0] RampBottomRst  = 8'd5;
  localparam logic [7:0] StepDividerRst = 8'd10;
  localparam logic [7:0] ShortLimitRst  = 8'd5;
  localparam logic [7:0] LongLimitRst   = 8'd10;

  // Saturation point of the press counter.
  localparam logic [7:0] PressCountMax = 8'hFF;

  typedef logic [7:0] byte_t;

  // Press timing thresholds handed to the press controller.
  typedef struct packed {
    byte_t short_limit;
    byte_t long_limit;
  } press_cfg_t;

  // Ramp settings handed to the PWM generator.
  typedef struct packed {
    byte_t ramp_top;
    byte_t ramp_bottom;
    byte_t step_divider;
  } ramp_cfg_t;

  // Mode flags that the press controller passes to the PWM generator.
  typedef struct packed {
    logic adjust_mode;
    logic output_enabled;
  } press_stat_t;

endpackage

FILE: src/sbpd_if.sv
// Valid/ready channel interfaces for the dimmer's input and result transactions.
interface sbpd_in_if;
  logic valid;
  logic ready;
  logic pwm_tick;
  logic slow_tick;
  logic button_pressed;

  modport source (output valid, output pwm_tick, output slow_tick, output button_pressed,
                  input ready);
  modport sink (input valid, input pwm_tick, input slow_tick, input button_pressed,
                output ready);
endinterface

interface sbpd_out_if;
  logic       valid;
  logic       ready;
  logic       led;
  logic [7:0] brightness;
  logic       adjusting;
  logic       led_enabled;

  modport source (output valid, output led, output brightness, output adjusting,
                  output led_enabled, input ready);
  modport sink (input valid, input led, input brightness, input adjusting,
                input led_enabled, output ready);
endinterface

FILE: src/sbpd_press_ctrl.sv
// Button press timer: short press toggles the LED, long hold enters adjust mode.
module sbpd_press_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic                 slow_tick,
  input  logic                 button_pressed,
  input  sbpd_pkg::press_cfg_t cfg,
  output sbpd_pkg::press_stat_t stat_nxt,
  output sbpd_pkg::press_stat_t stat
);
  import sbpd_pkg::*;

  byte_t press_count_r, press_count_nxt;
  logic  timer_on_r, timer_on_nxt;
  logic  adjust_r, adjust_nxt;
  logic  enabled_r, enabled_nxt;
  logic  button_prev_r;
  byte_t count_tick;

  // Slow tick first, then the button edges, as one combined update.
  always_comb begin
    press_count_nxt = press_count_r;
    timer_on_nxt    = timer_on_r;
    adjust_nxt      = adjust_r;
    enabled_nxt     = enabled_r;
    count_tick      = (press_count_r == PressCountMax) ? press_count_r : press_count_r + 8'd1;

    if (slow_tick && timer_on_r) begin
      press_count_nxt = count_tick;
      if (count_tick > cfg.long_limit) begin
        adjust_nxt = 1'b1;
      end
    end

    priority if (button_pressed && !button_prev_r) begin
      press_count_nxt = '0;
      timer_on_nxt    = 1'b1;
    end else if (!button_pressed && button_prev_r) begin
      priority if (press_count_nxt < cfg.short_limit) begin
        press_count_nxt = '0;
        enabled_nxt     = !enabled_r;
        timer_on_nxt    = 1'b0;
      end else if (press_count_nxt > cfg.long_limit) begin
        press_count_nxt = '0;
        adjust_nxt      = 1'b0;
        timer_on_nxt    = 1'b0;
      end else begin
        // A release between the limits leaves the timer running.
      end
    end else begin
      // No edge on the button.
    end
  end

  assign stat_nxt.adjust_mode    = adjust_nxt;
  assign stat_nxt.output_enabled = enabled_nxt;
  assign stat.adjust_mode        = adjust_r;
  assign stat.output_enabled     = enabled_r;

  // State registers advance once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_count_r <= '0;
      timer_on_r    <= 1'b0;
      adjust_r      <= 1'b0;
      enabled_r     <= 1'b1;
      button_prev_r <= 1'b0;
    end else if (step_en) begin
      press_count_r <= press_count_nxt;
      timer_on_r    <= timer_on_nxt;
      adjust_r      <= adjust_nxt;
      enabled_r     <= enabled_nxt;
      button_prev_r <= button_pressed;
    end
  end

`ifndef SYNTHESIS
  // The enable flips only on a transaction that carries a release edge.
  a_enable_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    !(step_en && button_prev_r && !button_pressed) |=> $stable(enabled_r))
    else $error("LED enable changed without a button release");

  // Adjust mode can only be entered on a slow tick with the timer running.
  a_adjust_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (!adjust_r && !(step_en && slow_tick && timer_on_r)) |=> !adjust_r)
    else $error("adjust mode entered without a timed slow tick");

  // A press edge always restarts the timer from zero.
  a_press_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && button_pressed && !button_prev_r) |=> (timer_on_r && press_count_r == '0))
    else $error("press edge did not restart the timer");
`endif
endmodule

FILE: src/sbpd_pwm_gen.sv
// PWM phase counter, LED pin level and brightness ramp of the dimmer.
module sbpd_pwm_gen (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic                  pwm_tick,
  input  sbpd_pkg::press_stat_t mode,
  input  sbpd_pkg::ramp_cfg_t   cfg,
  output logic                  led_nxt,
  output sbpd_pkg::byte_t       width_nxt
);
  import sbpd_pkg::*;

  logic [8:0] phase_cnt_r, phase_cnt_nxt, phase_inc;
  logic       high_phase_r, high_phase_nxt;
  byte_t      width_r;
  logic       rising_r, rising_nxt;
  byte_t      step_cnt_r, step_cnt_nxt;
  logic       led_r;
  byte_t      width_step;

  // Phase end handling: pin level, reload value and one possible ramp step.
  always_comb begin
    phase_inc      = phase_cnt_r + 9'd1;
    phase_cnt_nxt  = phase_cnt_r;
    high_phase_nxt = high_phase_r;
    led_nxt        = led_r;
    width_nxt      = width_r;
    rising_nxt     = rising_r;
    step_cnt_nxt   = step_cnt_r;
    width_step     = rising_r ? width_r + 8'd1 : width_r - 8'd1;

    if (pwm_tick) begin
      phase_cnt_nxt = phase_inc;
      if (phase_inc[8]) begin
        phase_cnt_nxt = '0;
        if (mode.output_enabled) begin
          if (!high_phase_r) begin
            high_phase_nxt = 1'b1;
            led_nxt        = 1'b1;
            phase_cnt_nxt  = {1'b0, ~width_r};
          end else begin
            high_phase_nxt = 1'b0;
            led_nxt        = 1'b0;
            phase_cnt_nxt  = {1'b0, width_r};
          end
        end else begin
          led_nxt = 1'b0;
        end

        if (mode.adjust_mode) begin
          if (step_cnt_r == cfg.step_divider) begin
            width_nxt = width_step;
            if (width_step == cfg.ramp_top) begin
              rising_nxt = 1'b0;
            end
            if (width_step == cfg.ramp_bottom) begin
              rising_nxt = 1'b1;
            end
            step_cnt_nxt = 8'd1;
          end else begin
            step_cnt_nxt = step_cnt_r + 8'd1;
          end
        end
      end
    end
  end

  // State registers advance once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_cnt_r  <= '0;
      high_phase_r <= 1'b0;
      width_r      <= '0;
      rising_r     <= 1'b1;
      step_cnt_r   <= '0;
      led_r        <= 1'b0;
    end else if (step_en) begin
      phase_cnt_r  <= phase_cnt_nxt;
      high_phase_r <= high_phase_nxt;
      width_r      <= width_nxt;
      rising_r     <= rising_nxt;
      step_cnt_r   <= step_cnt_nxt;
      led_r        <= led_nxt;
    end
  end

`ifndef SYNTHESIS
  // Between phase ends the counter always stays below the wrap point.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    !phase_cnt_r[8])
    else $error("phase counter reached the wrap point");

  // Brightness changes only at a phase end in adjust mode, by one step.
  a_width_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(step_en && pwm_tick && phase_inc[8] && mode.adjust_mode) |=> $stable(width_r))
    else $error("brightness changed outside an adjust-mode phase end");

  // The pin only goes high while the LED is enabled.
  a_led_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && led_nxt && !led_r) |-> mode.output_enabled)
    else $error("LED pin rose while output disabled");
`endif
endmodule

FILE: src/single_button_pwm_dimmer.sv
// Top level of the single-button PWM dimmer: configuration, handshake and result register.
//
// Usage: each input transaction on in_ch carries one base tick period (pwm_tick, slow_tick
// and the debounced button level). Every accepted input transaction produces exactly one
// result transaction on out_ch with the LED pin level, the brightness, the adjust flag and
// the LED enable, all showing the state after that input.
// The result is registered: it is valid in the cycle after acceptance. One transaction
// per clock is sustained while out_ch.ready stays high; the state update is a single pass of
// counters and compares between the state registers and the result register.
// in_ch.ready stays high while the result register is empty or is being emptied in the
// same cycle; when the receiver stalls with a result pending, input is held off and no
// state changes. Synchronous reset (rst_n low) returns the configuration to its defaults,
// the LED to enabled, brightness to zero and empties the result register.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must do so only while the
// block is idle, as the block itself does not enforce it. Unknown indexes are ignored.
module single_button_pwm_dimmer (
  input  logic              clk,
  input  logic              rst_n,
  sbpd_in_if.sink           in_ch,
  sbpd_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  sbpd_pkg::byte_t   cfg_data
);
  import sbpd_pkg::*;

  byte_t       ramp_top_r, ramp_bottom_r, step_div_r, short_lim_r, long_lim_r;
  press_cfg_t  press_cfg;
  ramp_cfg_t   ramp_cfg;
  press_stat_t stat_nxt, stat;
  logic        accept;
  logic        led_nxt;
  byte_t       width_nxt;
  logic        out_valid_r;
  logic        out_led_r;
  byte_t       out_bright_r;
  logic        out_adjust_r;
  logic        out_enabled_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_top_r    <= RampTopRst;
      ramp_bottom_r <= RampBottomRst;
      step_div_r    <= StepDividerRst;
      short_lim_r   <= ShortLimitRst;
      long_lim_r    <= LongLimitRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgRampTop:     ramp_top_r    <= cfg_data;
        CfgRampBottom:  ramp_bottom_r <= cfg_data;
        CfgStepDivider: step_div_r    <= cfg_data;
        CfgShortLimit:  short_lim_r   <= cfg_data;
        CfgLongLimit:   long_lim_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign press_cfg.short_limit  = short_lim_r;
  assign press_cfg.long_limit   = long_lim_r;
  assign ramp_cfg.ramp_top      = ramp_top_r;
  assign ramp_cfg.ramp_bottom   = ramp_bottom_r;
  assign ramp_cfg.step_divider  = step_div_r;

  // Input is taken whenever the result register is free or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  sbpd_press_ctrl u_press (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (accept),
    .slow_tick      (in_ch.slow_tick),
    .button_pressed (in_ch.button_pressed),
    .cfg            (press_cfg),
    .stat_nxt       (stat_nxt),
    .stat           (stat)
  );

  sbpd_pwm_gen u_pwm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (accept),
    .pwm_tick  (in_ch.pwm_tick),
    .mode      (stat_nxt),
    .cfg       (ramp_cfg),
    .led_nxt   (led_nxt),
    .width_nxt (width_nxt)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, loaded with the post-transaction state.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_led_r     <= led_nxt;
      out_bright_r  <= width_nxt;
      out_adjust_r  <= stat_nxt.adjust_mode;
      out_enabled_r <= stat_nxt.output_enabled;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.led         = out_led_r;
  assign out_ch.brightness  = out_bright_r;
  assign out_ch.adjusting   = out_adjust_r;
  assign out_ch.led_enabled = out_enabled_r;

`ifndef SYNTHESIS
  // A pending result that is not taken holds off new input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while a result was stalled");

  // Every accepted transaction yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction produced no result");

  // Mode flags shown in the result track the press controller's state.
  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_adjust_r == stat.adjust_mode && out_enabled_r == stat.output_enabled))
    else $error("result flags differ from controller state");
`endif
endmodule
